>>> rtl/nvl_pkg.sv
package nvl_pkg;

  localparam int DEF_CORDIC_STAGES  = 16;
  localparam int DEF_COMPONENT_BITS = 16;
  localparam int ATAN_TABLE_LEN     = 24;

  localparam int WORK_W      = 43;
  localparam int WORK_SCALE  = 40;
  localparam int ANG_W       = 26;
  localparam int LAT_W       = 24;
  localparam int LON_W       = 25;
  localparam int OUT_TDATA_W = 56;

  localparam int MAG_W      = 41;
  localparam int SPLIT      = 21;
  localparam int GAIN_W     = 20;
  localparam int PLO_W      = SPLIT + GAIN_W;
  localparam int PHI_W      = MAG_W - SPLIT + GAIN_W;
  localparam int SUM_W      = MAG_W + GAIN_W + 1;
  localparam int FRAC_SHIFT = 20;

  localparam logic [GAIN_W-1:0] INV_GAIN_Q20 = 20'd636750;
  localparam logic [SUM_W-1:0]  ROUND_HALF   = SUM_W'(1) << (FRAC_SHIFT - 1);

  localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360 = 26'sd23592960;

  typedef struct packed {
    logic degen;
    logic polar;
    logic yzero;
    logic xneg;
    logic zpos;
  } flags_t;

  function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117304;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/nvl_cordic_stage.sv
module nvl_cordic_stage #(
  parameter int SHIFT = 0,
  parameter int SBW   = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [nvl_pkg::WORK_W-1:0] in_x,
  input  logic signed [nvl_pkg::WORK_W-1:0] in_y,
  input  logic signed [nvl_pkg::ANG_W-1:0]  in_ang,
  input  logic [SBW-1:0]                   in_sb,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [nvl_pkg::WORK_W-1:0] out_x,
  output logic signed [nvl_pkg::WORK_W-1:0] out_y,
  output logic signed [nvl_pkg::ANG_W-1:0]  out_ang,
  output logic [SBW-1:0]                   out_sb
);
  import nvl_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = atan_deg(SHIFT);

  logic signed [WORK_W-1:0] dx, dy, x_next, y_next;
  logic signed [ANG_W-1:0]  ang_next;

  assign dx = in_x >>> SHIFT;
  assign dy = in_y >>> SHIFT;

  always_comb begin
    if (in_y > 0) begin
      x_next   = in_x + dy;
      y_next   = in_y - dx;
      ang_next = in_ang + ATAN;
    end else begin
      x_next   = in_x - dy;
      y_next   = in_y + dx;
      ang_next = in_ang - ATAN;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_x   <= x_next;
      out_y   <= y_next;
      out_ang <= ang_next;
      out_sb  <= in_sb;
    end
  end

endmodule

>>> rtl/nvector_to_latlon.sv
// n-vector to latitude / longitude converter.
// Input stream s_*: one word per vector, x, y, z as signed components of
// COMPONENT_BITS each, packed from the lowest bit of s_tdata.
// Output stream m_*: one word per input word, in order. m_tdata holds latitude
// (24 bits) then longitude (25 bits), both degrees * 65536; m_tuser is set for
// an all-zero vector, whose angles are then zero.
// Latitude is atan2(z, |xy|) and longitude atan2(y, x); the vector length
// does not matter.
// Pipeline: input register, one register per CORDIC iteration of the
// longitude pass, gain-correction multiply, partial-product sum, one
// register per iteration of the latitude pass, clamp and output register.
// Throughput: one word per cycle while m_tready is high, set by the fully
// pipelined CORDIC chain.
// Every stage carries its own valid bit and takes a new word whenever it is
// empty or its successor moves, so bubbles close up while m_tready is low;
// s_tready falls only once the whole pipeline is full.
// Reset (rst, synchronous) clears all valid bits; words in flight are dropped.
module nvector_to_latlon #(
  parameter int CORDIC_STAGES  = nvl_pkg::DEF_CORDIC_STAGES,
  parameter int COMPONENT_BITS = nvl_pkg::DEF_COMPONENT_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // vec_x, vec_y, vec_z, zero pad
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // latitude, longitude, zero pad
  output logic [nvl_pkg::OUT_TDATA_W-1:0] m_tdata,
  // degenerate
  output logic m_tuser
);
  import nvl_pkg::*;

  localparam int CB  = COMPONENT_BITS;
  localparam int WS  = WORK_SCALE - COMPONENT_BITS;
  localparam int NST = (CORDIC_STAGES > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STAGES;
  localparam int PAD_W = OUT_TDATA_W - LAT_W - LON_W;

  typedef struct packed {
    logic [CB-1:0]     z;
    logic [WORK_W-1:0] absx;
    flags_t            fl;
  } sb1_t;

  typedef struct packed {
    logic [LON_W-1:0] lon;
    flags_t           fl;
  } sb2_t;

  // input decode
  logic signed [CB-1:0]     in_x, in_y, in_z;
  logic signed [WORK_W-1:0] xs, ys;
  logic signed [WORK_W-1:0] cx0, cy0;
  logic signed [ANG_W-1:0]  base0;
  flags_t                   fl0;
  sb1_t                     sb0;

  assign in_x = s_tdata[CB-1:0];
  assign in_y = s_tdata[2*CB-1:CB];
  assign in_z = s_tdata[3*CB-1:2*CB];
  assign xs   = WORK_W'(in_x) <<< WS;
  assign ys   = WORK_W'(in_y) <<< WS;

  always_comb begin
    fl0.degen = (in_x == '0) && (in_y == '0) && (in_z == '0);
    fl0.polar = (in_x == '0) && (in_y == '0) && (in_z != '0);
    fl0.yzero = (in_y == '0);
    fl0.xneg  = in_x[CB-1];
    fl0.zpos  = !in_z[CB-1];
    if (in_x[CB-1]) begin
      if (!in_y[CB-1]) begin
        cx0   = ys;
        cy0   = -xs;
        base0 = DEG90;
      end else begin
        cx0   = -ys;
        cy0   = xs;
        base0 = -DEG90;
      end
    end else begin
      cx0   = xs;
      cy0   = ys;
      base0 = '0;
    end
    sb0.z    = in_z;
    sb0.absx = in_x[CB-1] ? -xs : xs;
    sb0.fl   = fl0;
  end

  // longitude pass
  logic                     p1_v    [NST+1];
  logic                     p1_take [NST+1];
  logic signed [WORK_W-1:0] p1_x    [NST+1];
  logic signed [WORK_W-1:0] p1_y    [NST+1];
  logic signed [ANG_W-1:0]  p1_ang  [NST+1];
  sb1_t                     p1_sb   [NST+1];

  logic                     in_v;
  logic signed [WORK_W-1:0] in_cx, in_cy;
  logic signed [ANG_W-1:0]  in_base;
  sb1_t                     in_sb;

  assign s_tready = !in_v || p1_take[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_cx   <= cx0;
      in_cy   <= cy0;
      in_base <= base0;
      in_sb   <= sb0;
    end
  end

  assign p1_v[0]   = in_v;
  assign p1_x[0]   = in_cx;
  assign p1_y[0]   = in_cy;
  assign p1_ang[0] = in_base;
  assign p1_sb[0]  = in_sb;

  for (genvar k = 0; k < NST; k++) begin : g_lon
    nvl_cordic_stage #(.SHIFT(k), .SBW($bits(sb1_t))) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (p1_v[k]),
      .in_ready  (p1_take[k]),
      .in_x      (p1_x[k]),
      .in_y      (p1_y[k]),
      .in_ang    (p1_ang[k]),
      .in_sb     (p1_sb[k]),
      .out_valid (p1_v[k+1]),
      .out_ready (p1_take[k+1]),
      .out_x     (p1_x[k+1]),
      .out_y     (p1_y[k+1]),
      .out_ang   (p1_ang[k+1]),
      .out_sb    (p1_sb[k+1])
    );
  end

  // longitude wrap and gain-correction partial products
  logic                     q1_v, q1_rdy;
  logic [LON_W-1:0]         q1_lon;
  logic [PLO_W-1:0]         q1_mlo;
  logic [PHI_W-1:0]         q1_mhi;
  logic [WORK_W-1:0]        q1_absx;
  logic [CB-1:0]            q1_z;
  flags_t                   q1_fl;

  logic signed [ANG_W-1:0]  ang1, lon_wrap, lon_sel;
  logic [MAG_W-1:0]         cxc;
  sb1_t                     sb1;

  assign ang1 = p1_ang[NST];
  assign sb1  = p1_sb[NST];
  assign cxc  = p1_x[NST][WORK_W-1] ? '0 : p1_x[NST][MAG_W-1:0];

  always_comb begin
    if (ang1 <= -DEG180) begin
      lon_wrap = ang1 + DEG360;
    end else if (ang1 > DEG180) begin
      lon_wrap = ang1 - DEG360;
    end else begin
      lon_wrap = ang1;
    end
    if (sb1.fl.degen || sb1.fl.polar) begin
      lon_sel = '0;
    end else if (sb1.fl.yzero) begin
      lon_sel = sb1.fl.xneg ? DEG180 : '0;
    end else begin
      lon_sel = lon_wrap;
    end
  end

  logic q2_rdy;
  assign q1_rdy        = !q1_v || q2_rdy;
  assign p1_take[NST]  = q1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_v <= 1'b0;
    end else if (q1_rdy) begin
      q1_v <= p1_v[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (q1_rdy) begin
      q1_lon  <= lon_sel[LON_W-1:0];
      q1_mlo  <= PLO_W'(cxc[SPLIT-1:0]) * PLO_W'(INV_GAIN_Q20);
      q1_mhi  <= PHI_W'(cxc[MAG_W-1:SPLIT]) * PHI_W'(INV_GAIN_Q20);
      q1_absx <= sb1.absx;
      q1_z    <= sb1.z;
      q1_fl   <= sb1.fl;
    end
  end

  // partial-product sum, feeds the latitude pass
  logic                     p2_v    [NST+1];
  logic                     p2_take [NST+1];
  logic signed [WORK_W-1:0] p2_x    [NST+1];
  logic signed [WORK_W-1:0] p2_y    [NST+1];
  logic signed [ANG_W-1:0]  p2_ang  [NST+1];
  sb2_t                     p2_sb   [NST+1];

  logic                     q2_v;
  logic signed [WORK_W-1:0] q2_r, q2_z;
  sb2_t                     q2_sb;
  logic [SUM_W-1:0]         msum;
  logic signed [CB-1:0]     z_raw;
  sb2_t                     sb2_next;

  assign msum  = (SUM_W'(q1_mhi) << SPLIT) + SUM_W'(q1_mlo) + ROUND_HALF;
  assign z_raw = q1_z;
  assign sb2_next.lon = q1_lon;
  assign sb2_next.fl  = q1_fl;

  assign q2_rdy = !q2_v || p2_take[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_v <= 1'b0;
    end else if (q2_rdy) begin
      q2_v <= q1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (q2_rdy) begin
      q2_r  <= q1_fl.yzero ? q1_absx : WORK_W'(msum[SUM_W-1:FRAC_SHIFT]);
      q2_z  <= WORK_W'(z_raw) <<< WS;
      q2_sb <= sb2_next;
    end
  end

  assign p2_v[0]   = q2_v;
  assign p2_x[0]   = q2_r;
  assign p2_y[0]   = q2_z;
  assign p2_ang[0] = '0;
  assign p2_sb[0]  = q2_sb;

  for (genvar k = 0; k < NST; k++) begin : g_lat
    nvl_cordic_stage #(.SHIFT(k), .SBW($bits(sb2_t))) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (p2_v[k]),
      .in_ready  (p2_take[k]),
      .in_x      (p2_x[k]),
      .in_y      (p2_y[k]),
      .in_ang    (p2_ang[k]),
      .in_sb     (p2_sb[k]),
      .out_valid (p2_v[k+1]),
      .out_ready (p2_take[k+1]),
      .out_x     (p2_x[k+1]),
      .out_y     (p2_y[k+1]),
      .out_ang   (p2_ang[k+1]),
      .out_sb    (p2_sb[k+1])
    );
  end

  // latitude clamp and output register
  logic                    out_rdy;
  logic signed [ANG_W-1:0] ang2, lat_sel;
  sb2_t                    sbf;
  logic [LAT_W-1:0]        lat;
  logic [LON_W-1:0]        lon;
  logic                    degen;

  assign ang2 = p2_ang[NST];
  assign sbf  = p2_sb[NST];

  always_comb begin
    if (sbf.fl.degen) begin
      lat_sel = '0;
    end else if (sbf.fl.polar) begin
      lat_sel = sbf.fl.zpos ? DEG90 : -DEG90;
    end else if (ang2 > DEG90) begin
      lat_sel = DEG90;
    end else if (ang2 < -DEG90) begin
      lat_sel = -DEG90;
    end else begin
      lat_sel = ang2;
    end
  end

  assign out_rdy      = !m_tvalid || m_tready;
  assign p2_take[NST] = out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_rdy) begin
      m_tvalid <= p2_v[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      lat   <= lat_sel[LAT_W-1:0];
      lon   <= sbf.lon;
      degen <= sbf.fl.degen;
    end
  end

  assign m_tdata = {PAD_W'(0), lon, lat};
  assign m_tuser = degen;

endmodule

>>> rtl/nvl_checker.sv
module nvl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [nvl_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser
);
  import nvl_pkg::*;

  logic signed [LAT_W-1:0] lat;
  logic signed [LON_W-1:0] lon;

  assign lat = m_tdata[LAT_W-1:0];
  assign lon = m_tdata[LAT_W+LON_W-1:LAT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate word with nonzero angles");

  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> lat <= DEG90 && lat >= -DEG90)
    else $error("latitude out of range");

  a_lon_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> lon <= DEG180 && lon > -DEG180)
    else $error("longitude out of range");

endmodule

bind nvector_to_latlon nvl_checker u_nvl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> dv/testbench.sv
module testbench;
  import nvl_pkg::*;

  localparam int STAGES = (DEF_CORDIC_STAGES > ATAN_TABLE_LEN) ?
                          ATAN_TABLE_LEN : DEF_CORDIC_STAGES;
  localparam longint COMP_SCALE = 64'sd1 << (WORK_SCALE - DEF_COMPONENT_BITS);
  localparam int DIR_N = 20;
  localparam int RAND_N = 1400;
  localparam int HOLD_CYCLES = 150;

  localparam longint ATAN_DEG [ATAN_TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic degen;
  } geo_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic known;
    geo_t fix;
  } probe_t;

  localparam probe_t PROBES [DIR_N] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{24'sd0, 25'sd0, 1'b1}},
    '{16'sd0, 16'sd0, 16'sd32767, 1'b1, '{24'sd5898240, 25'sd0, 1'b0}},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b1, '{-24'sd5898240, 25'sd0, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd1, 1'b1, '{24'sd5898240, 25'sd0, 1'b0}},
    '{16'sd0, 16'sd0, -16'sd1, 1'b1, '{-24'sd5898240, 25'sd0, 1'b0}},
    '{16'sd32767, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sh8000, 16'sd0, 16'sd0, 1'b0, '0},
    '{-16'sd1, 16'sd0, 16'sd5, 1'b0, '0},
    '{16'sd0, 16'sd32767, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sh8000, 16'sd0, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
    '{16'sh8000, 16'sd1, 16'sd0, 1'b0, '0},
    '{16'sh8000, -16'sd1, 16'sd0, 1'b0, '0},
    '{16'sd1, 16'sd1, 16'sd1, 1'b0, '0},
    '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0},
    '{16'sd32767, 16'sh8000, 16'sd32767, 1'b0, '0},
    '{16'sh8000, 16'sd32767, 16'sh8000, 1'b0, '0},
    '{16'sd21845, -16'sd21846, 16'sd21845, 1'b0, '0},
    '{-16'sd21846, 16'sd21845, -16'sd21846, 1'b0, '0}
  };

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  logic signed [LAT_W-1:0] got_lat;
  logic signed [LON_W-1:0] got_lon;

  geo_t pending_fixes [$];
  int fail_count = 0;
  int src_idle_pct = 35;
  int snk_idle_pct = 70;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  assign got_lat = m_tdata[LAT_W-1:0];
  assign got_lon = m_tdata[LAT_W+LON_W-1:LAT_W];

  nvector_to_latlon #(
    .CORDIC_STAGES (DEF_CORDIC_STAGES),
    .COMPONENT_BITS(DEF_COMPONENT_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rotate (xi, yi) onto the positive x axis; return magnitude and angle
  function automatic void vectoring(input longint xi, input longint yi,
                                    output longint mag, output longint ang);
    longint x, y, dx, dy;
    x = xi;
    y = yi;
    ang = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x = x + dy;
        y = y - dx;
        ang = ang + ATAN_DEG[i];
      end else begin
        x = x - dy;
        y = y + dx;
        ang = ang - ATAN_DEG[i];
      end
    end
    mag = x;
  endfunction

  function automatic geo_t locate(input logic signed [15:0] vx,
                                  input logic signed [15:0] vy,
                                  input logic signed [15:0] vz);
    longint x, y, z, cx, cy, mag, base, ang, lat, lon, r;
    geo_t g;
    x = longint'(vx) * COMP_SCALE;
    y = longint'(vy) * COMP_SCALE;
    z = longint'(vz) * COMP_SCALE;
    g.degen = 1'b0;
    lat = 0;
    lon = 0;
    if (x == 0 && y == 0 && z == 0) begin
      g.degen = 1'b1;
    end else if (x == 0 && y == 0) begin
      lat = (z > 0) ? longint'(DEG90) : -longint'(DEG90);
    end else begin
      if (y == 0) begin
        lon = (x > 0) ? 0 : longint'(DEG180);
        r = (x > 0) ? x : -x;
      end else begin
        base = 0;
        if (x < 0) begin
          if (y >= 0) begin
            cx = y;
            cy = -x;
            base = longint'(DEG90);
          end else begin
            cx = -y;
            cy = x;
            base = -longint'(DEG90);
          end
        end else begin
          cx = x;
          cy = y;
        end
        vectoring(cx, cy, mag, ang);
        lon = base + ang;
        if (lon <= -longint'(DEG180)) lon = lon + longint'(DEG360);
        if (lon > longint'(DEG180)) lon = lon - longint'(DEG360);
        if (mag < 0) mag = 0;
        r = (mag * longint'(INV_GAIN_Q20) + (64'sd1 << 19)) >>> 20;
      end
      vectoring(r, z, mag, lat);
      if (lat > longint'(DEG90)) lat = longint'(DEG90);
      if (lat < -longint'(DEG90)) lat = -longint'(DEG90);
    end
    g.lat = lat[LAT_W-1:0];
    g.lon = lon[LON_W-1:0];
    return g;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'sd0;
      1: v = $urandom_range(0, 1) ? 16'sd32767 : 16'sh8000;
      2: v = 16'($signed($urandom_range(0, 15)) - 8);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_vec(input logic signed [15:0] vx, input logic signed [15:0] vy,
                          input logic signed [15:0] vz, input logic known,
                          input geo_t typed);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {vz, vy, vx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_fixes.push_back(known ? typed : locate(vx, vy, vz));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIR_N; i++)
      send_vec(PROBES[i].x, PROBES[i].y, PROBES[i].z, PROBES[i].known, PROBES[i].fix);
    for (int i = 0; i < RAND_N; i++) begin
      if (i == RAND_N / 3) begin
        src_idle_pct = 70;
        snk_idle_pct = 35;
      end
      if (i == 2 * RAND_N / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_seq++;
      end
      send_vec(rand_comp(), rand_comp(), rand_comp(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (2 * STAGES + 20) @(posedge clk);
    if (fail_count == 0 && pending_fixes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  always @(posedge clk) begin : sink
    geo_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_fixes.size() == 0) begin
          $display("%0t: unexpected word, expected none, got lat %0d lon %0d degen %0b",
                   $time, got_lat, got_lon, m_tuser);
          fail_count++;
        end else begin
          want = pending_fixes.pop_front();
          if (got_lat !== want.lat) begin
            $display("%0t: latitude mismatch, expected %0d, got %0d",
                     $time, want.lat, got_lat);
            fail_count++;
          end
          if (got_lon !== want.lon) begin
            $display("%0t: longitude mismatch, expected %0d, got %0d",
                     $time, want.lon, got_lon);
            fail_count++;
          end
          if (m_tuser !== want.degen) begin
            $display("%0t: degenerate mismatch, expected %0b, got %0b",
                     $time, want.degen, m_tuser);
            fail_count++;
          end
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
